[hdl/alarm_clock_set_fsm_core_assert.svh]
// Assertion macros for the alarm clock mode controller.
`ifndef ALARM_CLOCK_SET_FSM_CORE_ASSERT_SVH
`define ALARM_CLOCK_SET_FSM_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, checked on clk, disabled in reset
`define ALCS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ALCS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ALCS_ASSERT_IMP(label, ante, cons, msg)
`define ALCS_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

[hdl/alcs_pkg.sv]
// Shared codes, limits, result type and step helpers of the alarm clock controller.
package alcs_pkg;

	// event codes carried in s_tuser
	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_CLOCK = 3'd1;
	localparam logic [2:0] CMD_MODE  = 3'd2;
	localparam logic [2:0] CMD_LONG  = 3'd3;
	localparam logic [2:0] CMD_INC   = 3'd4;
	localparam logic [2:0] CMD_DEC   = 3'd5;

	// clock chip write targets
	localparam logic [3:0] WF_HOUR   = 4'd0;
	localparam logic [3:0] WF_MIN    = 4'd1;
	localparam logic [3:0] WF_WDAY   = 4'd2;
	localparam logic [3:0] WF_DATE   = 4'd3;
	localparam logic [3:0] WF_MONTH  = 4'd4;
	localparam logic [3:0] WF_YEAR   = 4'd5;
	localparam logic [3:0] WF_AFLAG  = 4'd6;
	localparam logic [3:0] WF_AHOUR  = 4'd7;
	localparam logic [3:0] WF_AMIN   = 4'd8;

	// configuration register indexes
	localparam logic [1:0] CFG_ADJUST = 2'd0;
	localparam logic [1:0] CFG_RING   = 2'd1;
	localparam logic [1:0] CFG_ANIM   = 2'd2;
	localparam logic [1:0] CFG_BLINK  = 2'd3;

	// configuration reset values
	localparam logic [15:0] ADJUST_RST = 16'd10000;
	localparam logic [15:0] RING_RST   = 16'd60000;
	localparam logic [15:0] ANIM_RST   = 16'd500;
	localparam logic [15:0] BLINK_RST  = 16'd300;

	// field limits, on the common 7-bit edit width
	localparam logic [6:0] HOUR_MAX  = 7'd23;
	localparam logic [6:0] MIN_MAX   = 7'd59;
	localparam logic [6:0] WDAY_MAX  = 7'd7;
	localparam logic [6:0] DATE_MAX  = 7'd31;
	localparam logic [6:0] MONTH_MAX = 7'd12;
	localparam logic [6:0] YEAR_MAX  = 7'd99;
	localparam logic [6:0] ZERO_MIN  = 7'd0;
	localparam logic [6:0] ONE_MIN   = 7'd1;

	// one result item, mode_now in the lowest bits
	typedef struct packed {
		logic [6:0] write_value;
		logic [3:0] write_field;
		logic       write_valid;
		logic       tracking_clock;
		logic       alarm_enabled;
		logic       anim_frame;
		logic       cursor_visible;
		logic [3:0] mode_now;
	} result_t;

	function automatic logic [6:0] wrap_inc(logic [6:0] v, logic [6:0] lo, logic [6:0] hi);
		return (v < hi) ? v + 7'd1 : lo;
	endfunction

	function automatic logic [6:0] wrap_dec(logic [6:0] v, logic [6:0] lo, logic [6:0] hi);
		return (v > lo) ? v - 7'd1 : hi;
	endfunction

	function automatic logic [6:0] sat_inc(logic [6:0] v, logic [6:0] hi);
		return (v < hi) ? v + 7'd1 : hi;
	endfunction

	function automatic logic [6:0] sat_dec(logic [6:0] v, logic [6:0] lo);
		return (v > lo) ? v - 7'd1 : lo;
	endfunction

endpackage

[hdl/alarm_clock_set_fsm_core.sv]
// Alarm clock mode controller: edit modes, alarm set-up, ringing and clock writes.
//
//  channel   dir  handshake             payload
//  s_*       in   s_tvalid / s_tready   s_tuser command, s_tdata clock time fields
//  m_*       out  m_tvalid / m_tready   m_tdata mode, flags and clock write
//  cfg_*     in   cfg_we                cfg_index, cfg_wdata
//
// One request per cycle sustained while m_tready holds; a request goes from the input
// stage through the single-pass step logic into the result register.
// arst_n clears the mode, time, alarm and counter state and loads the default timings.
// A stalled result holds the result register; the input stage still takes one
// request, then s_tready drops until the result is taken.
`include "alarm_clock_set_fsm_core_assert.svh"

module alarm_clock_set_fsm_core
	import alcs_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tuser: command[2:0]
	input  logic [2:0]  s_tuser,
	// s_tdata: rtc_hour[4:0], rtc_minute[10:5], rtc_second[16:11], rtc_weekday[19:17],
	//          rtc_date[24:20], rtc_month[28:25], rtc_year[35:29], zero[39:36]
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: mode_now[3:0], cursor_visible[4], anim_frame[5], alarm_enabled[6],
	//          tracking_clock[7], write_valid[8], write_field[12:9], write_value[19:13],
	//          zero[23:20]
	output logic [23:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	typedef enum logic [3:0] {
		M_INIT   = 4'd0,
		M_NORMAL = 4'd1,
		M_ADJUST = 4'd2,
		M_HOUR   = 4'd3,
		M_MIN    = 4'd4,
		M_WDAY   = 4'd5,
		M_DATE   = 4'd6,
		M_MONTH  = 4'd7,
		M_YEAR   = 4'd8,
		M_AMENU  = 4'd9,
		M_AHOUR  = 4'd10,
		M_AMIN   = 4'd11,
		M_RING   = 4'd12
	} mode_t;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// configuration
	logic [15:0] adjust_q, ring_q, anim_per_q, blink_per_q;

	// input stage
	logic       valid_s1;
	logic [2:0] cmd_s1;
	logic [4:0] rhour_s1;
	logic [5:0] rmin_s1, rsec_s1;
	logic [2:0] rwday_s1;
	logic [4:0] rdate_s1;
	logic [3:0] rmonth_s1;
	logic [6:0] ryear_s1;

	// controller state
	mode_t      mode_q;
	logic [4:0] hour_q, ahour_q;
	logic [5:0] minute_q, second_q, amin_q;
	logic [2:0] wday_q;
	logic [4:0] date_q;
	logic [3:0] month_q;
	logic [6:0] year_q;
	logic       alarm_on_q, track_q, blink_ph_q, anim_ph_q;
	count_t     timeout_q, blink_q, anim_q;

	// result register
	logic    m_tvalid_q;
	result_t res_q;

	// next-state values
	mode_t      n_mode;
	logic [4:0] n_hour, n_ahour;
	logic [5:0] n_minute, n_second, n_amin;
	logic [2:0] n_wday;
	logic [4:0] n_date;
	logic [3:0] n_month;
	logic [6:0] n_year;
	logic       n_alarm_on, n_track, n_blink_ph, n_anim_ph;
	count_t     n_timeout, n_blink, n_anim;
	logic       n_wvalid;
	logic [3:0] n_wfield;
	logic [6:0] n_wvalue;

	// shared edit path
	logic       ed_en;
	logic [2:0] key, ed_key;
	logic [3:0] ed_field;
	mode_t      ed_next;
	logic [6:0] ed_cur, ed_inc, ed_dec, ed_new;

	logic adv;

	// a request leaves the input stage when the result register is free or drains
	assign adv      = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, res_q};

	// one step of the controller for the request in the input stage
	always_comb begin
		n_mode     = mode_q;
		n_hour     = hour_q;
		n_minute   = minute_q;
		n_second   = second_q;
		n_wday     = wday_q;
		n_date     = date_q;
		n_month    = month_q;
		n_year     = year_q;
		n_ahour    = ahour_q;
		n_amin     = amin_q;
		n_alarm_on = alarm_on_q;
		n_track    = track_q;
		n_blink_ph = blink_ph_q;
		n_anim_ph  = anim_ph_q;
		n_timeout  = timeout_q;
		n_blink    = blink_q;
		n_anim     = anim_q;
		n_wvalid   = 1'b0;
		n_wfield   = WF_HOUR;
		n_wvalue   = 7'd0;

		key = (cmd_s1 >= CMD_MODE && cmd_s1 <= CMD_DEC) ? cmd_s1 : CMD_TICK;

		// tick counts down, clock update loads the time while tracking
		if (cmd_s1 == CMD_TICK) begin
			if (n_timeout != '0) n_timeout = n_timeout - count_t'(1);
			if (n_blink != '0)   n_blink   = n_blink - count_t'(1);
			if (n_anim != '0)    n_anim    = n_anim - count_t'(1);
		end else if (cmd_s1 == CMD_CLOCK && track_q) begin
			n_hour   = rhour_s1;
			n_minute = rmin_s1;
			n_second = rsec_s1;
			n_wday   = rwday_s1;
			n_date   = rdate_s1;
			n_month  = rmonth_s1;
			n_year   = ryear_s1;
		end

		ed_en    = 1'b0;
		ed_key   = key;
		ed_field = WF_HOUR;
		ed_next  = M_INIT;
		ed_cur   = 7'd0;
		ed_inc   = 7'd0;
		ed_dec   = 7'd0;

		// mode logic
		unique case (mode_q)
			M_INIT: begin
				n_track = 1'b1;
				n_mode  = M_NORMAL;
			end
			M_NORMAL: begin
				if (alarm_on_q && n_hour == ahour_q && n_minute == amin_q
						&& n_second == 6'd0) begin
					n_timeout = count_t'(ring_q);
					n_mode    = M_RING;
				end
				if (key == CMD_MODE) begin
					n_mode = M_ADJUST;
				end else if (key == CMD_LONG) begin
					n_timeout = count_t'(adjust_q);
					n_track   = 1'b0;
					n_mode    = M_AMENU;
				end
			end
			M_ADJUST: begin
				n_track   = 1'b0;
				n_timeout = count_t'(adjust_q);
				n_mode    = M_HOUR;
			end
			M_HOUR: begin
				ed_en    = 1'b1;
				ed_field = WF_HOUR;
				ed_next  = M_MIN;
				ed_cur   = 7'(n_hour);
				ed_inc   = wrap_inc(ed_cur, ZERO_MIN, HOUR_MAX);
				ed_dec   = wrap_dec(ed_cur, ZERO_MIN, HOUR_MAX);
			end
			M_MIN: begin
				ed_en    = 1'b1;
				ed_field = WF_MIN;
				ed_next  = M_WDAY;
				ed_cur   = 7'(n_minute);
				ed_inc   = wrap_inc(ed_cur, ZERO_MIN, MIN_MAX);
				ed_dec   = wrap_dec(ed_cur, ZERO_MIN, MIN_MAX);
			end
			M_WDAY: begin
				ed_en    = 1'b1;
				ed_field = WF_WDAY;
				ed_next  = M_DATE;
				ed_cur   = 7'(n_wday);
				ed_inc   = wrap_inc(ed_cur, ONE_MIN, WDAY_MAX);
				ed_dec   = wrap_dec(ed_cur, ONE_MIN, WDAY_MAX);
			end
			M_DATE: begin
				ed_en    = 1'b1;
				ed_field = WF_DATE;
				ed_next  = M_MONTH;
				ed_cur   = 7'(n_date);
				ed_inc   = wrap_inc(ed_cur, ONE_MIN, DATE_MAX);
				ed_dec   = wrap_dec(ed_cur, ONE_MIN, DATE_MAX);
			end
			M_MONTH: begin
				ed_en    = 1'b1;
				ed_field = WF_MONTH;
				ed_next  = M_YEAR;
				ed_cur   = 7'(n_month);
				ed_inc   = sat_inc(ed_cur, MONTH_MAX);
				ed_dec   = sat_dec(ed_cur, ONE_MIN);
			end
			M_YEAR: begin
				ed_en    = 1'b1;
				ed_field = WF_YEAR;
				ed_next  = M_INIT;
				ed_cur   = n_year;
				ed_inc   = wrap_inc(ed_cur, ZERO_MIN, YEAR_MAX);
				ed_dec   = wrap_dec(ed_cur, ZERO_MIN, YEAR_MAX);
			end
			M_AMENU: begin
				if (key == CMD_DEC) begin
					n_alarm_on = 1'b1;
					n_wvalid   = 1'b1;
					n_wfield   = WF_AFLAG;
					n_wvalue   = 7'd1;
					n_timeout  = count_t'(adjust_q);
					n_mode     = M_AHOUR;
				end else if (key == CMD_INC) begin
					n_alarm_on = 1'b0;
					n_wvalid   = 1'b1;
					n_wfield   = WF_AFLAG;
					n_wvalue   = 7'd0;
					n_mode     = M_INIT;
				end else if (n_timeout == '0) begin
					n_mode = M_INIT;
				end
			end
			M_AHOUR: begin
				ed_en    = 1'b1;
				ed_field = WF_AHOUR;
				ed_next  = M_AMIN;
				ed_cur   = 7'(ahour_q);
				ed_inc   = wrap_inc(ed_cur, ZERO_MIN, HOUR_MAX);
				ed_dec   = wrap_dec(ed_cur, ZERO_MIN, HOUR_MAX);
			end
			M_AMIN: begin
				// an idle event after the timeout commits like a mode press
				ed_en    = 1'b1;
				ed_key   = (key == CMD_TICK && n_timeout == '0) ? CMD_MODE : key;
				ed_field = WF_AMIN;
				ed_next  = M_INIT;
				ed_cur   = 7'(amin_q);
				ed_inc   = wrap_inc(ed_cur, ZERO_MIN, MIN_MAX);
				ed_dec   = wrap_dec(ed_cur, ZERO_MIN, MIN_MAX);
			end
			M_RING: begin
				if (n_anim == '0) begin
					n_anim    = count_t'(anim_per_q);
					n_anim_ph = !anim_ph_q;
				end
				if (key == CMD_MODE || n_timeout == '0) n_mode = M_INIT;
			end
			default: begin
				n_mode = M_INIT;
			end
		endcase

		// edit modes: blink, then dec / inc / commit / commit and leave on timeout
		ed_new = ed_cur;
		if (ed_en) begin
			if (n_blink == '0) begin
				n_blink    = count_t'(blink_per_q);
				n_blink_ph = !blink_ph_q;
			end
			priority if (ed_key == CMD_DEC) begin
				n_timeout = count_t'(adjust_q);
				ed_new    = ed_dec;
			end else if (ed_key == CMD_INC) begin
				n_timeout = count_t'(adjust_q);
				ed_new    = ed_inc;
			end else if (ed_key == CMD_MODE) begin
				n_wvalid  = 1'b1;
				n_wfield  = ed_field;
				n_wvalue  = ed_cur;
				n_timeout = count_t'(adjust_q);
				n_mode    = ed_next;
			end else if (n_timeout == '0) begin
				n_wvalid = 1'b1;
				n_wfield = ed_field;
				n_wvalue = ed_cur;
				n_mode   = M_INIT;
			end
		end

		// write the edited value back to its field
		unique case (mode_q)
			M_HOUR:  n_hour   = ed_new[4:0];
			M_MIN:   n_minute = ed_new[5:0];
			M_WDAY:  n_wday   = ed_new[2:0];
			M_DATE:  n_date   = ed_new[4:0];
			M_MONTH: n_month  = ed_new[3:0];
			M_YEAR:  n_year   = ed_new;
			M_AHOUR: n_ahour  = ed_new[4:0];
			M_AMIN:  n_amin   = ed_new[5:0];
			default: ;
		endcase
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1    <= s_tuser;
			rhour_s1  <= s_tdata[4:0];
			rmin_s1   <= s_tdata[10:5];
			rsec_s1   <= s_tdata[16:11];
			rwday_s1  <= s_tdata[19:17];
			rdate_s1  <= s_tdata[24:20];
			rmonth_s1 <= s_tdata[28:25];
			ryear_s1  <= s_tdata[35:29];
		end
	end

	// configuration, state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adjust_q    <= ADJUST_RST;
			ring_q      <= RING_RST;
			anim_per_q  <= ANIM_RST;
			blink_per_q <= BLINK_RST;
			valid_s1    <= 1'b0;
			mode_q      <= M_INIT;
			hour_q      <= 5'd0;
			minute_q    <= 6'd0;
			second_q    <= 6'd0;
			wday_q      <= 3'd1;
			date_q      <= 5'd1;
			month_q     <= 4'd1;
			year_q      <= 7'd0;
			ahour_q     <= 5'd0;
			amin_q      <= 6'd0;
			alarm_on_q  <= 1'b0;
			track_q     <= 1'b0;
			blink_ph_q  <= 1'b0;
			anim_ph_q   <= 1'b0;
			timeout_q   <= '0;
			blink_q     <= '0;
			anim_q      <= '0;
			m_tvalid_q  <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ADJUST: adjust_q    <= cfg_wdata;
					CFG_RING:   ring_q      <= cfg_wdata;
					CFG_ANIM:   anim_per_q  <= cfg_wdata;
					CFG_BLINK:  blink_per_q <= cfg_wdata;
				endcase
			end

			if (s_tready) valid_s1 <= s_tvalid;

			if (adv) begin
				mode_q     <= n_mode;
				hour_q     <= n_hour;
				minute_q   <= n_minute;
				second_q   <= n_second;
				wday_q     <= n_wday;
				date_q     <= n_date;
				month_q    <= n_month;
				year_q     <= n_year;
				ahour_q    <= n_ahour;
				amin_q     <= n_amin;
				alarm_on_q <= n_alarm_on;
				track_q    <= n_track;
				blink_ph_q <= n_blink_ph;
				anim_ph_q  <= n_anim_ph;
				timeout_q  <= n_timeout;
				blink_q    <= n_blink;
				anim_q     <= n_anim;

				res_q.mode_now       <= n_mode;
				res_q.cursor_visible <= n_blink_ph;
				res_q.anim_frame     <= n_anim_ph;
				res_q.alarm_enabled  <= n_alarm_on;
				res_q.tracking_clock <= n_track;
				res_q.write_valid    <= n_wvalid;
				res_q.write_field    <= n_wfield;
				res_q.write_value    <= n_wvalue;
			end

			if (adv) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// checks
	`ALCS_ASSERT_NXT(a_adv_gives_result, adv, m_tvalid_q, "request left stage without result")
	`ALCS_ASSERT_IMP(a_idle_write_zero, m_tvalid_q && !res_q.write_valid, res_q.write_field == WF_HOUR && res_q.write_value == 7'd0, "idle write carries data")
	`ALCS_ASSERT_IMP(a_ring_needs_alarm, mode_q == M_RING, alarm_on_q, "ringing with alarm disarmed")
	`ALCS_ASSERT_IMP(a_edit_not_tracking, mode_q >= M_HOUR && mode_q <= M_AMIN, !track_q, "clock tracked while editing")

endmodule
